FILE: src/dmci_pkg.sv
// shared constants, types and helpers for the disk minimum cost inflation block
`timescale 1ns / 1ps

package dmci_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int MAX_RADIUS = 8;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COST_W  = 16;
    localparam int WORD_W  = COST_W + 1;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;

    // scan window and distance arithmetic
    localparam int WIN     = 2 * MAX_RADIUS + 1;
    localparam int WIN_W   = $clog2(WIN + 1);
    localparam int OFF_W   = WIN_W + 1;
    localparam int POS_W   = $clog2(MAX_ROWS + MAX_COLS + 2 * MAX_RADIUS) + 1;
    localparam int DIST_W  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 2);
    localparam int RSQ_W   = (CFG_W > DIST_W) ? CFG_W : DIST_W;
    localparam int RSQ_MAX = MAX_RADIUS * MAX_RADIUS;

    // stream payload layout
    localparam int ROW_LSB    = 0;
    localparam int COL_LSB    = ROW_LSB + ROW_W;
    localparam int COST_LSB   = COL_LSB + COL_W;
    localparam int VLD_BIT    = COST_LSB + COST_W;
    localparam int S_TDATA_W  = ((VLD_BIT + 1 + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((COST_W + 7) / 8) * 8;

    localparam logic [COST_W-1:0] COST_FULL = '1;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS      = 2'd0,
        CFG_COLS      = 2'd1,
        CFG_RADIUS_SQ = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } store_wr_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

    // square of a window offset, index minus radius
    function automatic logic [DIST_W-1:0] off_sq(input logic [WIN_W-1:0] idx);
        logic signed [OFF_W-1:0]   off;
        logic signed [2*OFF_W-1:0] prod;
        off  = $signed(OFF_W'(idx)) - $signed(OFF_W'(MAX_RADIUS));
        prod = off * off;
        return prod[DIST_W-1:0];
    endfunction

endpackage

FILE: src/disk_min_cost_inflation.sv
// top level: cost grid with disk minimum queries
// a query inside the grid steps through the WIN*WIN (289) window positions, one per cycle,
// reading cells inside the disk and grid, then passes ST_FLUSH and registers its result
// in ST_DONE once the output register is free; s_tready returns in the cycle after that
// after reset the store is swept clear, all DEPTH (4096) cells, with s_tready low
// configuration writes are taken at any time, registers reset to 64, 64, 0
`timescale 1ns / 1ps

module disk_min_cost_inflation (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // row, col, cost_in, cell_valid, zero fill
    input  logic [dmci_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // cost_out
    output logic [dmci_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic [dmci_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dmci_pkg::CFG_W-1:0]     cfg_data
);
    import dmci_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH, ST_DONE} state_t;

    state_t            state_reg;
    logic [CFG_W-1:0]  grid_rows_reg;
    logic [CFG_W-1:0]  grid_cols_reg;
    logic [CFG_W-1:0]  radius_sq_reg;
    logic [ROW_W-1:0]  row0_reg;
    logic [COL_W-1:0]  col0_reg;
    logic [WIN_W-1:0]  dr_reg;
    logic [WIN_W-1:0]  dc_reg;
    logic              use_reg;
    logic [COST_W-1:0] best_reg;
    logic              m_tvalid_reg;
    logic [COST_W-1:0] m_tdata_reg;

    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [COST_W-1:0] in_cost;
    logic              in_vld;
    logic [CFG_W-1:0]  rows_eff;
    logic [CFG_W-1:0]  cols_eff;
    logic [RSQ_W-1:0]  rsq_eff;
    logic              in_inside;
    logic              accept;
    logic signed [POS_W-1:0] r_pos;
    logic signed [POS_W-1:0] c_pos;
    logic [DIST_W-1:0] d2;
    logic              hit;
    logic              rd_en;
    logic [WORD_W-1:0] rd_data;
    logic              store_busy;
    store_wr_t         wr;

    assign in_row  = s_tdata[ROW_LSB +: ROW_W];
    assign in_col  = s_tdata[COL_LSB +: COL_W];
    assign in_cost = s_tdata[COST_LSB +: COST_W];
    assign in_vld  = s_tdata[VLD_BIT];

    assign rows_eff = (int'(grid_rows_reg) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : grid_rows_reg;
    assign cols_eff = (int'(grid_cols_reg) > MAX_COLS) ? CFG_W'(MAX_COLS) : grid_cols_reg;
    assign rsq_eff  = (int'(radius_sq_reg) > RSQ_MAX) ? RSQ_W'(RSQ_MAX)
                                                      : RSQ_W'(radius_sq_reg);

    assign in_inside = (CFG_W'(in_row) < rows_eff) && (CFG_W'(in_col) < cols_eff);

    assign s_tready = (state_reg == ST_IDLE) && !store_busy;
    assign accept   = s_tvalid && s_tready;

    // window position and disk test for the current scan step
    assign r_pos = $signed(POS_W'(row0_reg)) + $signed(POS_W'(dr_reg))
                   - $signed(POS_W'(MAX_RADIUS));
    assign c_pos = $signed(POS_W'(col0_reg)) + $signed(POS_W'(dc_reg))
                   - $signed(POS_W'(MAX_RADIUS));
    assign d2    = off_sq(dr_reg) + off_sq(dc_reg);

    assign hit = (RSQ_W'(d2) <= rsq_eff)
              && (r_pos >= 0) && (r_pos < $signed(POS_W'(rows_eff)))
              && (c_pos >= 0) && (c_pos < $signed(POS_W'(cols_eff)));

    assign rd_en = (state_reg == ST_SCAN) && hit;

    assign wr.en   = accept && (s_tuser == REQ_LOAD) && in_inside;
    assign wr.addr = cell_addr(in_row, in_col);
    assign wr.data = {in_vld, in_cost};

    dmci_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (cell_addr(r_pos[ROW_W-1:0], c_pos[COL_W-1:0])),
        .rd_data (rd_data),
        .busy    (store_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= CFG_W'(64);
            grid_cols_reg <= CFG_W'(64);
            radius_sq_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROWS:      grid_rows_reg <= cfg_data;
                CFG_COLS:      grid_cols_reg <= cfg_data;
                CFG_RADIUS_SQ: radius_sq_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row0_reg     <= '0;
            col0_reg     <= '0;
            dr_reg       <= '0;
            dc_reg       <= '0;
            use_reg      <= 1'b0;
            best_reg     <= COST_FULL;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            use_reg <= rd_en;
            // compare the word read in the previous cycle
            if (use_reg && rd_data[COST_W] && (rd_data[COST_W-1:0] < best_reg))
            begin
                best_reg <= rd_data[COST_W-1:0];
            end
            // in ST_DONE the valid flag is handled by the state itself
            if ((state_reg != ST_DONE) && m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (s_tuser == REQ_QUERY))
                    begin
                        row0_reg <= in_row;
                        col0_reg <= in_col;
                        best_reg <= COST_FULL;
                        dr_reg   <= '0;
                        dc_reg   <= '0;
                        state_reg <= in_inside ? ST_SCAN : ST_DONE;
                    end
                end
                ST_SCAN:
                begin
                    if (dc_reg == WIN_W'(WIN - 1))
                    begin
                        dc_reg <= '0;
                        dr_reg <= dr_reg + 1'b1;
                        if (dr_reg == WIN_W'(WIN - 1))
                        begin
                            state_reg <= ST_FLUSH;
                        end
                    end
                    else
                    begin
                        dc_reg <= dc_reg + 1'b1;
                    end
                end
                ST_FLUSH:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= best_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_tdata_reg);

endmodule

FILE: src/dmci_store.sv
// cell store: cost and valid flag per cell, cleared by a sweep after reset
`timescale 1ns / 1ps

module dmci_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dmci_pkg::store_wr_t       wr,
    input  logic                      rd_en,
    input  logic [dmci_pkg::ADDR_W-1:0] rd_addr,
    output logic [dmci_pkg::WORD_W-1:0] rd_data,
    output logic                      busy
);
    import dmci_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clearing_reg;
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clearing_reg;

endmodule

FILE: src/dmci_checker.sv
// port-level checks for the disk minimum cost inflation block
`timescale 1ns / 1ps

module dmci_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [dmci_pkg::M_TDATA_W-1:0] m_tdata
);
    import dmci_pkg::*;

    // a load finishes in the cycle it is transferred
    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_LOAD)) |=> s_tready)
        else $error("block not ready after a load");

    // a query holds off the next item
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == REQ_QUERY)) |=> !s_tready)
        else $error("input taken while a query is in progress");

    // a new result only comes out of a finished query
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared while the block was idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result changed while stalled");

endmodule

bind disk_min_cost_inflation dmci_checker u_dmci_checker (.*);
